FILE: sv/q2s_pkg.sv
// Shared types and constants for the quaternion to servo target block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package q2s_pkg;

	// register indexes on the configuration channel
	localparam logic [2:0] REG_YAW_GAIN     = 3'd0;
	localparam logic [2:0] REG_PITCH_GAIN   = 3'd1;
	localparam logic [2:0] REG_ROLL_GAIN    = 3'd2;
	localparam logic [2:0] REG_YAW_OFFSET   = 3'd3;
	localparam logic [2:0] REG_PITCH_OFFSET = 3'd4;
	localparam logic [2:0] REG_ROLL_OFFSET  = 3'd5;

	localparam logic [2:0] POSE_FIST   = 3'd1;
	localparam logic [2:0] POSE_SPREAD = 3'd4;

	localparam logic [11:0] GRIP_MID  = 12'd2048;
	localparam logic [11:0] GRIP_HIGH = 12'd3072;
	localparam logic [11:0] GRIP_LOW  = 12'd1024;

	// which angle the shared CORDIC is resolving
	localparam logic [1:0] SEL_ROLL  = 2'd0;
	localparam logic [1:0] SEL_YAW   = 2'd1;
	localparam logic [1:0] SEL_PITCH = 2'd2;

	localparam int MUL_LAST  = 8;
	localparam int SQRT_LAST = 27;

	typedef struct packed {
		logic       load;
		logic       mul;
		logic       prep;
		logic       square;
		logic       sqrt_step;
		logic       cinit;
		logic       crun;
		logic       csave;
		logic       scale;
		logic       svmul;
		logic       svadj;
		logic       svrcp;
		logic       finish;
		logic [5:0] cnt;
		logic [1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

	// arctan(2^-i) with 2^32 units per turn
	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			5'd31: r = 32'd0;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/q2s_ctrl.sv
// Sequencer for the quaternion to servo datapath.
// Depends on q2s_pkg for the command and status structs.
`default_nettype none
module q2s_ctrl import q2s_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	localparam int CR_N = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_PREP  = 4'd2;
	localparam logic [3:0] ST_SQ    = 4'd3;
	localparam logic [3:0] ST_SQRT  = 4'd4;
	localparam logic [3:0] ST_CINIT = 4'd5;
	localparam logic [3:0] ST_CRUN  = 4'd6;
	localparam logic [3:0] ST_CSAVE = 4'd7;
	localparam logic [3:0] ST_SCALE = 4'd8;
	localparam logic [3:0] ST_SVMUL = 4'd9;
	localparam logic [3:0] ST_SVADJ = 4'd10;
	localparam logic [3:0] ST_SVRCP = 4'd11;
	localparam logic [3:0] ST_FIN   = 4'd12;

	logic [3:0] state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic [1:0] sel_q, sel_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.cnt = cnt_q;
		cmd.sel = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d   = cnt_q + 6'd1;
				if (cnt_q == 6'(MUL_LAST)) state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_SQ;
			end
			ST_SQ: begin
				cmd.square = 1'b1;
				cnt_d      = '0;
				state_d    = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 6'd1;
				if (cnt_q == 6'(SQRT_LAST)) begin
					sel_d   = SEL_ROLL;
					state_d = ST_CINIT;
				end
			end
			ST_CINIT: begin
				cmd.cinit = 1'b1;
				cnt_d     = '0;
				state_d   = ST_CRUN;
			end
			ST_CRUN: begin
				cmd.crun = 1'b1;
				cnt_d    = cnt_q + 6'd1;
				if (cnt_q == 6'(CR_N - 1)) state_d = ST_CSAVE;
			end
			ST_CSAVE: begin
				cmd.csave = 1'b1;
				if (sel_q == SEL_PITCH) begin
					state_d = ST_SCALE;
				end else begin
					sel_d   = sel_q + 2'd1;
					state_d = ST_CINIT;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_SVMUL;
			end
			ST_SVMUL: begin
				cmd.svmul = 1'b1;
				state_d   = ST_SVADJ;
			end
			ST_SVADJ: begin
				cmd.svadj = 1'b1;
				state_d   = ST_SVRCP;
			end
			ST_SVRCP: begin
				cmd.svrcp = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				// wait for the output register to be free
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sel_q   <= SEL_ROLL;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
		end
	end

endmodule
`default_nettype wire

FILE: sv/q2s_dpath.sv
// Datapath: quaternion products, square root, shared CORDIC, scaling and servo maths.
// Depends on q2s_pkg; driven by q2s_ctrl commands.
`default_nettype none
module q2s_dpath import q2s_pkg::*; #(
	parameter int SCALE_FRAC_BITS = 12,
	parameter int QUAT_WIDTH      = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output stat_t                      stat,
	input  wire logic [4*QUAT_WIDTH-1:0] quat_in,
	input  wire logic [2:0]            pose_in,
	input  wire logic [9:0]            yaw_gain,
	input  wire logic [9:0]            pitch_gain,
	input  wire logic [9:0]            roll_gain,
	input  wire logic [11:0]           yaw_offset,
	input  wire logic [11:0]           pitch_offset,
	input  wire logic [11:0]           roll_offset,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [70:0]                out_data
);

	localparam int F   = SCALE_FRAC_BITS;
	localparam int QW  = QUAT_WIDTH;
	localparam int SHR = (QW >= 16) ? QW - 16 : 0;
	localparam int SHL = (QW < 16) ? 16 - QW : 0;
	localparam int SW  = F + 5;
	localparam int NW  = SW + 16;
	localparam int XW  = 36;
	localparam int ZW  = 35;

	localparam logic signed [ZW-1:0] HALF_T    = ZW'(64'sd2147483648);
	localparam logic signed [ZW-1:0] QUARTER_T = ZW'(64'sd1073741824);
	localparam logic [19:0]          RCP25     = 20'd671089; // ceil(2^24/25)

	localparam logic [3:0] P_XX = 4'd0, P_YY = 4'd1, P_ZZ = 4'd2, P_WX = 4'd3,
		P_YZ = 4'd4, P_WZ = 4'd5, P_XY = 4'd6, P_WY = 4'd7, P_ZX = 4'd8;

	// input scaling to Q1.14
	logic signed [15:0] comp_in [4];
	for (genvar k = 0; k < 4; k++) begin : g_load
		logic signed [47:0] ext;
		assign ext        = 48'($signed(quat_in[k*QW +: QW]));
		assign comp_in[k] = 16'((ext >>> SHR) <<< SHL);
	end

	logic signed [15:0] q_q [4];
	logic [2:0]         pose_q;
	logic signed [31:0] prod_q [9];

	logic signed [15:0] ma, mb;
	always_comb begin
		unique case (cmd.cnt[3:0])
			P_XX: begin ma = q_q[1]; mb = q_q[1]; end
			P_YY: begin ma = q_q[2]; mb = q_q[2]; end
			P_ZZ: begin ma = q_q[3]; mb = q_q[3]; end
			P_WX: begin ma = q_q[0]; mb = q_q[1]; end
			P_YZ: begin ma = q_q[2]; mb = q_q[3]; end
			P_WZ: begin ma = q_q[0]; mb = q_q[3]; end
			P_XY: begin ma = q_q[1]; mb = q_q[2]; end
			P_WY: begin ma = q_q[0]; mb = q_q[2]; end
			P_ZX: begin ma = q_q[3]; mb = q_q[1]; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// vectors and clamped sine term
	logic signed [33:0] half_one, rvx, rvy, yvx, yvy, sdiff;
	logic signed [28:0] s_clamp;
	always_comb begin
		half_one = 34'sd134217728;
		rvx   = half_one - (34'(prod_q[P_XX]) + 34'(prod_q[P_YY]));
		rvy   = 34'(prod_q[P_WX]) + 34'(prod_q[P_YZ]);
		yvx   = half_one - (34'(prod_q[P_YY]) + 34'(prod_q[P_ZZ]));
		yvy   = 34'(prod_q[P_WZ]) + 34'(prod_q[P_XY]);
		sdiff = 34'(prod_q[P_WY]) - 34'(prod_q[P_ZX]);
		priority if (sdiff > half_one)  s_clamp = 29'sd134217728;
		else if (sdiff < -half_one)     s_clamp = -29'sd134217728;
		else                            s_clamp = 29'(sdiff);
	end

	logic signed [33:0] rvx_q, rvy_q, yvx_q, yvy_q;
	logic signed [28:0] s_q;
	logic signed [57:0] s_sq;
	assign s_sq = s_q * s_q;

	// digit-by-digit square root, two radicand bits a step
	logic [55:0] rad_q;
	logic [29:0] rem_q;
	logic [27:0] root_q;
	logic [29:0] rem_t, trial;
	assign rem_t = {rem_q[27:0], rad_q[55:54]};
	assign trial = {root_q, 2'b01};

	// CORDIC vectoring
	logic signed [XW-1:0] cx_q, cy_q, x0, y0, dx, dy;
	logic signed [ZW-1:0] cz_q, at;
	logic                 zero_q;
	always_comb begin
		unique case (cmd.sel)
			SEL_ROLL: begin x0 = XW'(rvx_q); y0 = XW'(rvy_q); end
			SEL_YAW:  begin x0 = XW'(yvx_q); y0 = XW'(yvy_q); end
			default:  begin x0 = $signed({8'b0, root_q}); y0 = XW'(s_q); end
		endcase
	end
	assign dx = cx_q >>> cmd.cnt[4:0];
	assign dy = cy_q >>> cmd.cnt[4:0];
	assign at = $signed(ZW'(atan_entry(cmd.cnt[4:0])));

	logic signed [ZW-1:0] zc;
	always_comb begin
		priority if (zero_q)       zc = '0;
		else if (cz_q > HALF_T)    zc = HALF_T;
		else if (cz_q < -HALF_T)   zc = -HALF_T;
		else                       zc = cz_q;
		if (cmd.sel == SEL_PITCH) begin
			priority if (zc > QUARTER_T)   zc = QUARTER_T;
			else if (zc < -QUARTER_T)      zc = -QUARTER_T;
			else                           zc = zc;
		end
	end

	logic signed [32:0] roll_q, yaw_q, pitch_q;

	// angle to 0..18 scale
	logic [33:0] ur, uy, up;
	logic [37:0] r18, y18, p36;
	always_comb begin
		ur  = 34'($signed(roll_q) + 34'sd2147483648);
		uy  = 34'($signed(yaw_q) + 34'sd2147483648);
		up  = 34'($signed(pitch_q) + 34'sd1073741824);
		r18 = (38'(ur) << 4) + (38'(ur) << 1);
		y18 = (38'(uy) << 4) + (38'(uy) << 1);
		p36 = (38'(up) << 5) + (38'(up) << 2);
	end

	logic [SW-1:0]    rs_q, ys_q, ps_q;
	logic [SW+9:0]    yp_q, pp_q, rp_q;

	// servo arithmetic
	logic [15:0]          pv, rv;
	logic signed [NW-1:0] n_y, p18, o25, mag;
	always_comb begin
		pv  = 16'(pp_q >> F) + 16'(pitch_offset);
		rv  = 16'(rp_q >> F) + 16'(roll_offset);
		p18 = $signed((NW'(yp_q) << 4) + (NW'(yp_q) << 1));
		o25 = $signed(((NW'(yaw_offset) << 4) + (NW'(yaw_offset) << 3) + NW'(yaw_offset)) << F);
		n_y = p18 - o25;
		mag = n_y[NW-1] ? -n_y : n_y;
	end

	logic [14:0] pitch_sv_q, roll_sv_q;
	logic [19:0] a_q;
	logic        neg_q;
	logic [39:0] rprod_q;
	logic [14:0] quo;
	assign quo = rprod_q[38:24];

	logic [15:0] yaw_out_q;
	logic [14:0] pitch_out_q, roll_out_q;
	logic        closed_q, closed_d;

	always_comb begin
		closed_d = closed_q;
		if (pose_q == POSE_FIST)        closed_d = 1'b1;
		else if (pose_q == POSE_SPREAD) closed_d = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < 4; k++) q_q[k] <= comp_in[k];
			pose_q <= pose_in;
		end
		if (cmd.mul) prod_q[cmd.cnt[3:0]] <= 32'(ma * mb);
		if (cmd.prep) begin
			rvx_q <= rvx; rvy_q <= rvy;
			yvx_q <= yvx; yvy_q <= yvy;
			s_q   <= s_clamp;
		end
		if (cmd.square) begin
			rad_q  <= (56'd1 << 54) - 56'(s_sq);
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q <= rad_q << 2;
			if (rem_t >= trial) begin
				rem_q  <= rem_t - trial;
				root_q <= {root_q[26:0], 1'b1};
			end else begin
				rem_q  <= rem_t;
				root_q <= {root_q[26:0], 1'b0};
			end
		end
		if (cmd.cinit) begin
			zero_q <= (x0 == '0) && (y0 == '0);
			if (x0 < 0) begin
				cx_q <= -x0;
				cy_q <= -y0;
				cz_q <= (y0 >= 0) ? HALF_T : -HALF_T;
			end else begin
				cx_q <= x0;
				cy_q <= y0;
				cz_q <= '0;
			end
		end
		if (cmd.crun) begin
			if (cy_q >= 0) begin
				cx_q <= cx_q + dy; cy_q <= cy_q - dx; cz_q <= cz_q + at;
			end else begin
				cx_q <= cx_q - dy; cy_q <= cy_q + dx; cz_q <= cz_q - at;
			end
		end
		if (cmd.csave) begin
			unique case (cmd.sel)
				SEL_ROLL: roll_q  <= 33'(zc);
				SEL_YAW:  yaw_q   <= 33'(zc);
				default:  pitch_q <= 33'(zc);
			endcase
		end
		if (cmd.scale) begin
			rs_q <= SW'(r18 >> (32 - F));
			ys_q <= SW'(y18 >> (32 - F));
			ps_q <= SW'(p36 >> (32 - F));
		end
		if (cmd.svmul) begin
			yp_q <= (SW+10)'(ys_q) * (SW+10)'(yaw_gain);
			pp_q <= (SW+10)'(ps_q) * (SW+10)'(pitch_gain);
			rp_q <= (SW+10)'(rs_q) * (SW+10)'(roll_gain);
		end
		if (cmd.svadj) begin
			pitch_sv_q <= (pv > 16'd32767) ? 15'h7FFF : pv[14:0];
			roll_sv_q  <= (rv > 16'd32767) ? 15'h7FFF : rv[14:0];
			a_q        <= 20'(mag >> F);
			neg_q      <= n_y[NW-1];
		end
		// quotient by 25 through the reciprocal; exact for operands below 2^19
		if (cmd.svrcp) rprod_q <= 40'(a_q) * 40'(RCP25);
		if (cmd.finish) begin
			yaw_out_q   <= neg_q ? -16'(quo) : 16'(quo);
			pitch_out_q <= pitch_sv_q;
			roll_out_q  <= roll_sv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			closed_q  <= 1'b1;
		end else begin
			if (cmd.finish) begin
				out_valid <= 1'b1;
				closed_q  <= closed_d;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign stat.out_free = !out_valid || out_ready;

	assign out_data = {closed_q,
		closed_q ? GRIP_MID : GRIP_LOW,
		closed_q ? GRIP_MID : GRIP_HIGH,
		roll_out_q, pitch_out_q, yaw_out_q};

endmodule
`default_nettype wire

FILE: sv/quaternion_to_servo_targets.sv
// Each item passes through nine shared products, a 28-step square root and three
// CORDIC runs. One item is in progress at a time: the next input transfer is taken
// once the previous item has reached the output register, so a waiting result does
// not block it.
// Reset: arst_n clears control, loads register defaults and sets the gripper closed.
`default_nettype none
module quaternion_to_servo_targets import q2s_pkg::*; #(
	parameter int CORDIC_STEPS    = 16,
	parameter int SCALE_FRAC_BITS = 12,
	parameter int QUAT_WIDTH      = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// quat_w, quat_x, quat_y, quat_z, zero fill
	input  wire logic [((4*QUAT_WIDTH+7)/8)*8-1:0] s_tdata,
	// pose_code
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// yaw_servo, pitch_servo, roll_servo, grip_first, grip_second, gripper_closed, zero fill
	output logic [71:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);

	logic [9:0]  yaw_gain_q, pitch_gain_q, roll_gain_q;
	logic [11:0] yaw_offset_q, pitch_offset_q, roll_offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_gain_q     <= 10'd500;
			pitch_gain_q   <= 10'd130;
			roll_gain_q    <= 10'd130;
			yaw_offset_q   <= 12'd1028;
			pitch_offset_q <= 12'd880;
			roll_offset_q  <= 12'd880;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_YAW_GAIN:     yaw_gain_q     <= cfg_data[9:0];
				REG_PITCH_GAIN:   pitch_gain_q   <= cfg_data[9:0];
				REG_ROLL_GAIN:    roll_gain_q    <= cfg_data[9:0];
				REG_YAW_OFFSET:   yaw_offset_q   <= cfg_data;
				REG_PITCH_OFFSET: pitch_offset_q <= cfg_data;
				REG_ROLL_OFFSET:  roll_offset_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	cmd_t        cmd;
	stat_t       stat;
	logic [70:0] out_data;

	q2s_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	q2s_dpath #(
		.SCALE_FRAC_BITS(SCALE_FRAC_BITS),
		.QUAT_WIDTH     (QUAT_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.quat_in      (s_tdata[4*QUAT_WIDTH-1:0]),
		.pose_in      (s_tuser),
		.yaw_gain     (yaw_gain_q),
		.pitch_gain   (pitch_gain_q),
		.roll_gain    (roll_gain_q),
		.yaw_offset   (yaw_offset_q),
		.pitch_offset (pitch_offset_q),
		.roll_offset  (roll_offset_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_data     (out_data)
	);

	assign m_tdata = {1'b0, out_data};

`ifndef SYNTHESIS
	// one item at a time: an input transfer closes the input side
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in progress");

	a_grip_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[70] ? (m_tdata[57:46] == GRIP_MID)
			: (m_tdata[57:46] == GRIP_HIGH)))
		else $error("first gripper target disagrees with flag");

	a_grip_second: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[70] ? (m_tdata[69:58] == GRIP_MID)
			: (m_tdata[69:58] == GRIP_LOW)))
		else $error("second gripper target disagrees with flag");
`endif

endmodule
`default_nettype wire
